@@ rtl/core/anx_pkg.sv @@
// ============================================================================
// anx_pkg
// Shared types and constants for the Annex B start code NAL splitter.
// ============================================================================
`default_nettype none

package anx_pkg;

    // Input operation codes.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Stream byte values that make up a start code.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    // Largest number of zeros held back as a possible start code.
    localparam logic [1:0] ZERO_MAX = 2'd3;

    // Number of result beats one input beat can cause.
    localparam int BURST_MAX = 4;

    // Depth of the burst queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One output beat.
    typedef struct packed {
        logic [7:0] nal_byte;
        logic       first;
        logic       last;
    } t_res;

    // All results caused by one input beat; last_idx is the count minus one.
    typedef struct packed {
        t_res [BURST_MAX-1:0] res;
        logic [1:0]           last_idx;
    } t_burst;

    // Status of the burst queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

`default_nettype wire

@@ rtl/core/anx_front.sv @@
// ============================================================================
// anx_front
// Accepts stream beats, tracks start codes and the held payload byte, and
// turns each beat into a burst of up to four result beats.
// ============================================================================
`default_nettype none

module anx_front
    import anx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_data_byte,
    input  wire t_queue_stat i_stat,
    output logic             o_push,
    output t_burst           o_burst
);

    logic       r_hunting, n_hunting;
    logic [1:0] r_pending_zeros, n_pending_zeros;
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_first, n_held_first;
    logic       r_unit_started, n_unit_started;

    logic       w_accept;
    logic [2:0] w_push_cnt;
    logic [1:0] w_zero_cnt;
    logic       w_close;
    logic [2:0] w_emit_cnt;
    t_burst     w_burst;

    assign o_in_ready = !i_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    // Classify the beat: how many payload bytes it adds and whether it closes a unit.
    always_comb begin
        n_hunting       = r_hunting;
        n_pending_zeros = r_pending_zeros;
        w_push_cnt      = 3'd0;
        w_zero_cnt      = 2'd0;
        w_close         = 1'b0;
        if (i_operation == OP_FLUSH) begin
            if (!r_hunting) begin
                w_push_cnt = {1'b0, r_pending_zeros};
                w_zero_cnt = r_pending_zeros;
                w_close    = 1'b1;
            end
            n_hunting       = 1'b1;
            n_pending_zeros = 2'd0;
        end else if (r_hunting) begin
            if (i_data_byte == BYTE_ZERO) begin
                if (r_pending_zeros != ZERO_MAX) begin
                    n_pending_zeros = r_pending_zeros + 2'd1;
                end
            end else if (i_data_byte == BYTE_ONE && r_pending_zeros >= 2'd2) begin
                n_hunting       = 1'b0;
                n_pending_zeros = 2'd0;
            end else begin
                n_pending_zeros = 2'd0;
            end
        end else begin
            if (i_data_byte == BYTE_ZERO) begin
                if (r_pending_zeros != ZERO_MAX) begin
                    n_pending_zeros = r_pending_zeros + 2'd1;
                end else begin
                    // The oldest of four zeros can no longer be part of a code.
                    w_push_cnt = 3'd1;
                end
            end else if (i_data_byte == BYTE_ONE && r_pending_zeros >= 2'd2) begin
                w_close         = 1'b1;
                n_pending_zeros = 2'd0;
            end else begin
                w_push_cnt      = {1'b0, r_pending_zeros} + 3'd1;
                w_zero_cnt      = r_pending_zeros;
                n_pending_zeros = 2'd0;
            end
        end
    end

    // Run the pushes through the held byte, then close the unit if asked.
    always_comb begin
        logic [7:0] v_byte;
        v_byte         = BYTE_ZERO;
        n_held_valid   = r_held_valid;
        n_held_byte    = r_held_byte;
        n_held_first   = r_held_first;
        n_unit_started = r_unit_started;
        w_emit_cnt     = 3'd0;
        w_burst        = '0;
        for (int k = 0; k < BURST_MAX; k++) begin
            if (3'(k) < w_push_cnt) begin
                v_byte = (3'(k) < {1'b0, w_zero_cnt}) ? BYTE_ZERO : i_data_byte;
                if (n_held_valid) begin
                    w_burst.res[w_emit_cnt[1:0]] = '{nal_byte: n_held_byte,
                                                     first: n_held_first, last: 1'b0};
                    w_emit_cnt = w_emit_cnt + 3'd1;
                end
                n_held_valid   = 1'b1;
                n_held_byte    = v_byte;
                n_held_first   = !n_unit_started;
                n_unit_started = 1'b1;
            end
        end
        if (w_close) begin
            if (n_held_valid) begin
                w_burst.res[w_emit_cnt[1:0]] = '{nal_byte: n_held_byte,
                                                 first: n_held_first, last: 1'b1};
                w_emit_cnt = w_emit_cnt + 3'd1;
            end
            n_held_valid   = 1'b0;
            n_held_byte    = BYTE_ZERO;
            n_held_first   = 1'b0;
            n_unit_started = 1'b0;
        end
        // A start code found while hunting opens an empty unit.
        if (i_operation == OP_BYTE && r_hunting && !n_hunting) begin
            n_held_valid   = 1'b0;
            n_held_byte    = BYTE_ZERO;
            n_held_first   = 1'b0;
            n_unit_started = 1'b0;
        end
        w_burst.last_idx = w_emit_cnt[1:0] - 2'd1;
    end

    assign o_push  = w_accept && (w_emit_cnt != 3'd0);
    assign o_burst = w_burst;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting       <= 1'b1;
            r_pending_zeros <= 2'd0;
            r_held_valid    <= 1'b0;
            r_held_byte     <= BYTE_ZERO;
            r_held_first    <= 1'b0;
            r_unit_started  <= 1'b0;
        end else if (w_accept) begin
            r_hunting       <= n_hunting;
            r_pending_zeros <= n_pending_zeros;
            r_held_valid    <= n_held_valid;
            r_held_byte     <= n_held_byte;
            r_held_first    <= n_held_first;
            r_unit_started  <= n_unit_started;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/anx_queue.sv @@
// ============================================================================
// anx_queue
// Two-entry queue of result bursts between the front and the back.
// ============================================================================
`default_nettype none

module anx_queue
    import anx_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_burst i_burst,
    input  wire logic   i_pop,
    output t_burst      o_head,
    output t_queue_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_burst             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Burst storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_burst;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/anx_back.sv @@
// ============================================================================
// anx_back
// Walks the head burst one result beat per cycle into the output register when not stalled.
// ============================================================================
`default_nettype none

module anx_back
    import anx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_burst      i_head,
    input  wire t_queue_stat i_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_nal_byte,
    output logic             o_nal_first,
    output logic             o_nal_last,
    output logic             o_burst_end
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_res       r_res;
    logic       r_burst_end;
    logic       w_load;
    logic       w_at_end;

    // Load a new beat when the output register is free or being taken.
    assign w_load   = !i_stat.empty && (!r_out_valid || i_out_ready);
    assign w_at_end = (r_idx == i_head.last_idx);
    assign o_pop    = w_load && w_at_end;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_idx       = w_at_end ? 2'd0 : r_idx + 2'd1;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res       <= i_head.res[r_idx];
            r_burst_end <= w_at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_nal_byte  = r_res.nal_byte;
    assign o_nal_first = r_res.first;
    assign o_nal_last  = r_res.last;
    assign o_burst_end = r_burst_end;

endmodule

`default_nettype wire

@@ rtl/core/annexb_nal_splitter.sv @@
// ============================================================================
// annexb_nal_splitter
// Splits an Annex B byte stream into NAL unit payload bytes.
// ============================================================================
// The block takes one stream beat per clock while the burst queue has room and
// strips the start codes 00 00 01 and 00 00 00 01, dropping anything before
// the first code; each output beat carries one payload byte with first and
// last marks, and burst_end marks the last output beat caused by an input
// beat. A flush beat ends the open unit and returns to hunting. Results pass
// the burst queue and the output register; a beat causes zero to four, and
// the back end drains the two-entry queue one byte per clock while out_ready
// holds; ordinary streams, with at most one byte per beat, run at one beat
// per clock on both sides unless stalled. Empty units produce nothing.
`default_nettype none

module annexb_nal_splitter
    import anx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_nal_byte,
    output logic            o_nal_first,
    output logic            o_nal_last,
    output logic            o_burst_end
);

    logic        w_push;
    logic        w_pop;
    t_burst      w_burst;
    t_burst      w_head;
    t_queue_stat w_stat;

    // Front end: start code tracking and burst building.
    anx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_stat      (w_stat),
        .o_push      (w_push),
        .o_burst     (w_burst)
    );

    // Burst queue.
    anx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_burst (w_burst),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Back end: one result beat per cycle while the output is taken.
    anx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_stat      (w_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_nal_byte  (o_nal_byte),
        .o_nal_first (o_nal_first),
        .o_nal_last  (o_nal_last),
        .o_burst_end (o_burst_end)
    );

    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("burst written into a full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("burst popped from an empty queue");

    // Closing a unit is always the last result of its input beat.
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nal_last) |-> o_burst_end)
        else $error("unit end not at burst end");

endmodule

`default_nettype wire

@@ tb/sv/annexb_nal_splitter_check.sv @@
// ============================================================================
// annexb_nal_splitter_check
// Predicts and checks the NAL byte beats of the Annex B start code splitter.
// ============================================================================
// Watches both handshakes of the splitter. Every accepted stream beat runs
// through a cycle-free model of the start code search. The model queues the
// payload bytes that the beat releases. Every accepted output beat is compared
// field by field with the oldest queued byte. The counts are handed to the
// testbench top through registered outputs.
`default_nettype none

module annexb_nal_splitter_check
    import anx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_nal_byte,
    input  wire logic       i_nal_first,
    input  wire logic       i_nal_last,
    input  wire logic       i_burst_end,
    output int              o_errors,
    output int              o_pending,
    output int              o_beats_in,
    output int              o_flushes,
    output int              o_bytes_out,
    output int              o_units
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] nal_byte;
        logic       first;
        logic       last;
        logic       burst_end;
    } nal_beat_t;

    nal_beat_t  nal_expected[$];
    nal_beat_t  burst_buf[BURST_MAX];
    int         burst_len = 0;

    // Model state of the start code search.
    logic       seeking    = 1'b1;
    logic [1:0] zero_run   = 2'd0;
    logic       hold_ok    = 1'b0;
    logic [7:0] hold_byte  = 8'h00;
    logic       hold_first = 1'b0;
    logic       unit_open  = 1'b0;

    int err_cnt   = 0;
    int beats_cnt = 0;
    int flush_cnt = 0;
    int bytes_cnt = 0;
    int units_cnt = 0;

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_beats_in  = 0;
        o_flushes   = 0;
        o_bytes_out = 0;
        o_units     = 0;
    end

    // Record one payload byte released by the current stream beat.
    function void release_byte(logic [7:0] b, logic first, logic last);
        if (burst_len < BURST_MAX) begin
            burst_buf[burst_len] = '{nal_byte: b, first: first, last: last,
                                     burst_end: 1'b0};
        end
        burst_len++;
    endfunction

    // A new payload byte pushes the held one out, not yet marked last.
    function void take_payload(logic [7:0] b);
        if (hold_ok) begin
            release_byte(hold_byte, hold_first, 1'b0);
        end
        hold_ok    = 1'b1;
        hold_byte  = b;
        hold_first = !unit_open;
        unit_open  = 1'b1;
    endfunction

    // The unit ends: the held byte leaves with the last mark.
    function void close_nal();
        if (hold_ok) begin
            release_byte(hold_byte, hold_first, 1'b1);
        end
        hold_ok    = 1'b0;
        hold_byte  = 8'h00;
        hold_first = 1'b0;
        unit_open  = 1'b0;
        zero_run   = 2'd0;
    endfunction

    function void back_to_hunt();
        seeking    = 1'b1;
        zero_run   = 2'd0;
        hold_ok    = 1'b0;
        hold_byte  = 8'h00;
        hold_first = 1'b0;
        unit_open  = 1'b0;
    endfunction

    // Work out the payload bytes that one accepted stream beat releases.
    function void predict_split(logic op, logic [7:0] b);
        int k;
        burst_len = 0;
        if (op == OP_FLUSH) begin
            // Held zeros turn into payload before the open unit is closed.
            if (!seeking) begin
                for (k = 0; k < zero_run; k++) begin
                    take_payload(BYTE_ZERO);
                end
                close_nal();
            end
            back_to_hunt();
        end else if (seeking) begin
            if (b == BYTE_ZERO) begin
                if (zero_run != ZERO_MAX) begin
                    zero_run++;
                end
            end else if (b == BYTE_ONE && zero_run >= 2) begin
                back_to_hunt();
                seeking = 1'b0;
            end else begin
                zero_run = 2'd0;
            end
        end else begin
            // Beyond three zeros, each further zero is payload for sure.
            if (b == BYTE_ZERO) begin
                if (zero_run != ZERO_MAX) begin
                    zero_run++;
                end else begin
                    take_payload(BYTE_ZERO);
                end
            end else if (b == BYTE_ONE && zero_run >= 2) begin
                close_nal();
            end else begin
                for (k = 0; k < zero_run; k++) begin
                    take_payload(BYTE_ZERO);
                end
                zero_run = 2'd0;
                take_payload(b);
            end
        end
        for (k = 0; k < burst_len && k < BURST_MAX; k++) begin
            if (k == burst_len - 1) begin
                burst_buf[k].burst_end = 1'b1;
            end
            nal_expected.push_back(burst_buf[k]);
        end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Compare one accepted output beat with the oldest expected byte.
    function void check_nal_beat();
        nal_beat_t want;
        bytes_cnt++;
        if (i_nal_last === 1'b1) begin
            units_cnt++;
        end
        if (nal_expected.size() == 0) begin
            $error("nal_byte %0h arrived with no byte expected", i_nal_byte);
            err_cnt++;
        end else begin
            want = nal_expected.pop_front();
            compare_field("nal_byte", want.nal_byte, i_nal_byte);
            compare_field("nal_first", {7'd0, want.first}, {7'd0, i_nal_first});
            compare_field("nal_last", {7'd0, want.last}, {7'd0, i_nal_last});
            compare_field("burst_end", {7'd0, want.burst_end}, {7'd0, i_burst_end});
        end
    endfunction

    // Output beats are checked before the input beat of the same edge is
    // predicted, since no result can leave in the cycle its cause arrives.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            back_to_hunt();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_nal_beat();
            end
            if (i_in_valid && i_in_ready) begin
                beats_cnt++;
                if (i_operation == OP_FLUSH) begin
                    flush_cnt++;
                end
                predict_split(i_operation, i_data_byte);
            end
        end
        o_errors    <= err_cnt;
        o_pending   <= nal_expected.size();
        o_beats_in  <= beats_cnt;
        o_flushes   <= flush_cnt;
        o_bytes_out <= bytes_cnt;
        o_units     <= units_cnt;
    end

endmodule

`default_nettype wire

@@ tb/sv/annexb_nal_splitter_test.sv @@
// ============================================================================
// annexb_nal_splitter_test
// Stimulus and verdict for the Annex B start code NAL splitter.
// ============================================================================
// Sends a directed stream that walks through the start code corner cases,
// then random streams made mostly of well-formed units with noise and
// flushes mixed in. Sender and receiver stall at random in the first two of
// three phases, and the receiver once holds off for a long stretch so that the
// splitter backs up into its input. The checker module does all comparing.
`default_nettype none

module annexb_nal_splitter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import anx_pkg::*;

    // Idling phases: slow receiver, slow sender, then full rate.
    localparam int PH_SLOW_RX = 0;
    localparam int PH_SLOW_TX = 1;
    localparam int PH_FULL    = 2;

    localparam int RANDOM_PER_PHASE = 100;
    localparam int HOLD_CYCLES      = 120;
    localparam int DRAIN_CYCLES     = 12;
    localparam int CYCLE_LIMIT      = 200000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       operation  = OP_BYTE;
    logic [7:0] data_byte  = 8'h00;
    logic       out_ready  = 1'b0;
    wire logic  in_ready;
    wire logic  out_valid;
    wire logic  [7:0] nal_byte;
    wire logic  nal_first;
    wire logic  nal_last;
    wire logic  burst_end;

    int phase = PH_SLOW_RX;
    int beats_sent = 0;

    int errors;
    int pending;
    int beats_in;
    int flushes;
    int bytes_out;
    int units;

    annexb_nal_splitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_operation (operation),
        .i_data_byte (data_byte),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_nal_byte  (nal_byte),
        .o_nal_first (nal_first),
        .o_nal_last  (nal_last),
        .o_burst_end (burst_end)
    );

    annexb_nal_splitter_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_operation (operation),
        .i_data_byte (data_byte),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_nal_byte  (nal_byte),
        .i_nal_first (nal_first),
        .i_nal_last  (nal_last),
        .i_burst_end (burst_end),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_beats_in  (beats_in),
        .o_flushes   (flushes),
        .o_bytes_out (bytes_out),
        .o_units     (units)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the splitter hangs.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d bytes pending", cycles, pending);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls per phase, plus one long hold-off at full rate.
    initial begin
        int  hold_left;
        bit  hold_done;
        int  idle_pct;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            idle_pct = (phase == PH_SLOW_RX) ? 87 : (phase == PH_SLOW_TX) ? 38 : 0;
            if (phase == PH_FULL && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Offer one beat, with random gaps first, and wait until it is taken.
    task automatic send_beat(input logic op, input logic [7:0] b);
        int idle_pct;
        idle_pct = (phase == PH_SLOW_RX) ? 38 : (phase == PH_SLOW_TX) ? 87 : 0;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // One random run: mostly a start code and a payload, sometimes noise or
    // a flush. Payloads are rich in zeros and ones so that zero runs and
    // broken start codes turn up inside units.
    task automatic send_random_run();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 8) begin
            n = $urandom_range(6, 1);
            repeat (n) send_beat(OP_BYTE, 8'($urandom_range(255)));
        end else if (pick < 15) begin
            send_beat(OP_FLUSH, 8'($urandom_range(255)));
        end else begin
            n = ($urandom_range(9) < 7) ? $urandom_range(3, 2) : $urandom_range(5, 4);
            repeat (n) send_beat(OP_BYTE, BYTE_ZERO);
            send_beat(OP_BYTE, BYTE_ONE);
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
            repeat (n) begin
                case ($urandom_range(9))
                    0, 1, 2: b = BYTE_ZERO;
                    3:       b = BYTE_ONE;
                    default: b = 8'($urandom_range(255));
                endcase
                send_beat(OP_BYTE, b);
            end
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // A single zero before 01 is no start code while hunting.
        send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_BYTE, BYTE_ONE);
        // A long zero run saturates the count and still opens a unit.
        repeat (4) send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_BYTE, BYTE_ONE);
        // Four zeros then 01: the first zero is payload, the rest is the code.
        send_beat(OP_BYTE, 8'h7F);
        repeat (4) send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_BYTE, BYTE_ONE);
        // A start code right after a start code leaves an empty unit.
        repeat (2) send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_BYTE, BYTE_ONE);
        // Three held zeros released by a payload byte give a burst of four.
        send_beat(OP_BYTE, 8'h80);
        repeat (3) send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_BYTE, 8'h42);
        // Flush while a unit is open turns the held zeros into payload.
        repeat (2) send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_FLUSH, 8'hFF);
        // Flush while hunting gives nothing and clears the zero count.
        repeat (2) send_beat(OP_BYTE, BYTE_ZERO);
        send_beat(OP_FLUSH, BYTE_ZERO);
        send_beat(OP_BYTE, BYTE_ONE);

        for (int p = PH_SLOW_RX; p <= PH_FULL; p++) begin
            phase <= p;
            target = beats_sent + RANDOM_PER_PHASE;
            while (beats_sent < target) send_random_run();
        end
        in_valid <= 1'b0;

        // Let the checker's counts catch up with the last beat, then drain.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d stream beats, %0d of them flushes, over three stall phases.",
                 beats_in, flushes);
        $display("Checked %0d NAL bytes closing %0d units, with one long output stall.",
                 bytes_out, units);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
